### rtl/utf8_to_utf16_transcoder_assert.svh
// Assertion macros for the transcoder; clk and rst are taken from the using scope.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication.
`define U8U16_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("transcoder check failed");

// Next-cycle implication.
`define U8U16_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("transcoder check failed");

`endif

### rtl/u8u16_pkg.sv
package u8u16_pkg;

  localparam int PENDING_DEPTH = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
  localparam logic [20:0] SURR_FIRST     = 21'h00D800;
  localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;

  typedef enum logic [1:0] {
    KIND_UNIT      = 2'd0,
    KIND_REMAINDER = 2'd1,
    KIND_STATUS    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAN       = 3'd0,
    ST_INCOMPLETE  = 3'd1,
    ST_STRAY       = 3'd2,
    ST_MALFORMED   = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } symbol_t;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] value;
    status_t     end_status;
    logic        last_result;
  } result_t;

  // Work handed from the decoder to the emitter for one request.
  typedef struct packed {
    logic                                has_point;
    logic                                utf32;
    logic [20:0]                         point;
    logic [1:0]                          rem_count;
    logic [PENDING_DEPTH-1:0][7:0]       rem_bytes;
    logic                                has_status;
    status_t                             status;
  } job_t;

endpackage

### rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16/UTF-32 transcoder. One byte is taken per cycle while full is low; a
// decoder classifies it at once against up to three held bytes and hands any work to a
// two-entry job queue. The emitter drains the head job one result per cycle through an
// output register while that register is empty or popped, and keeps a job until all of
// its results (at most four: a surrogate pair, or remainder bytes plus the end status) are
// out; full rises only when the queue holds two jobs. The first result of a byte passes
// through the queue entry and then the output register on its way to the result ports.
// Bytes that complete nothing (leads, held continuations, bytes after a halt) are taken
// but produce no result. output_utf32 is sampled when the byte is taken.
module utf8_to_utf16_transcoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  u8u16_pkg::symbol_t symbol,
  input  logic               pop,
  output logic               empty,
  output u8u16_pkg::result_t result,
  input  logic               cfg_write,
  input  logic               cfg_data
);

  `include "utf8_to_utf16_transcoder_assert.svh"

  logic            output_utf32;
  logic            accept;
  logic            new_valid;
  u8u16_pkg::job_t new_job;
  u8u16_pkg::job_t head_job;
  logic            head_valid;
  logic            head_done;
  logic            show_status;
  logic            show_data;
  logic            show_remainder;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_utf32 <= 1'b0;
    end else if (cfg_write) begin
      output_utf32 <= cfg_data;
    end
  end

  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .symbol    (symbol),
    .utf32     (output_utf32),
    .job_valid (new_valid),
    .job       (new_job)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (new_valid),
    .wr_job    (new_job),
    .rd_en     (head_done),
    .rd_job    (head_job),
    .not_empty (head_valid),
    .full      (full)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (head_valid),
    .job_done  (head_done),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign show_status    = !empty && result.kind == u8u16_pkg::KIND_STATUS;
  assign show_data      = !empty && result.kind != u8u16_pkg::KIND_STATUS;
  assign show_remainder = !empty && result.kind == u8u16_pkg::KIND_REMAINDER;

  `U8U16_ASSERT_NOW(status_is_last, show_status, result.last_result && result.value == 21'd0)
  `U8U16_ASSERT_NOW(status_only_on_end, show_data, result.end_status == u8u16_pkg::ST_CLEAN)
  `U8U16_ASSERT_NOW(remainder_is_byte, show_remainder, result.value[20:8] == 13'd0)
  `U8U16_ASSERT_NEXT(queued_work_shows, head_valid && empty, !empty)

endmodule

### rtl/u8u16_front.sv
module u8u16_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  u8u16_pkg::symbol_t symbol,
  input  logic               utf32,
  output logic               job_valid,
  output u8u16_pkg::job_t    job
);

  logic [7:0]                          pend [u8u16_pkg::PENDING_DEPTH];
  logic [1:0]                          count;
  logic [1:0]                          count_next;
  logic [2:0]                          seq_len;
  logic [2:0]                          seq_len_next;
  logic                                halted;
  logic                                halted_next;
  u8u16_pkg::status_t                  halt_status;
  u8u16_pkg::status_t                  halt_status_next;
  logic                                pend_wr;
  logic [1:0]                          pend_idx;
  logic [2:0]                          total;
  logic                                cont_ok;
  logic [7:0]                          b;
  logic [u8u16_pkg::PENDING_DEPTH-1:0][7:0] pend_view;

  assign b     = symbol.byte_in;
  assign total = {1'b0, count} + 3'd1;

  always_comb begin
    cont_ok = (b[7:6] == 2'b10)
           && (count < 2'd2 || pend[1][7:6] == 2'b10)
           && (count < 2'd3 || pend[2][7:6] == 2'b10);
  end

  always_comb begin
    halted_next      = halted;
    halt_status_next = halt_status;
    count_next       = count;
    seq_len_next     = seq_len;
    pend_wr          = 1'b0;
    pend_idx         = count;
    job              = '0;
    job.utf32        = utf32;

    if (!halted) begin
      if (count == 2'd0) begin
        pend_idx = 2'd0;
        if (b[7:6] == 2'b10) begin
          halted_next      = 1'b1;
          halt_status_next = u8u16_pkg::ST_STRAY;
        end else if (!b[7]) begin
          job.has_point = 1'b1;
          job.point     = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          pend_wr      = 1'b1;
          count_next   = 2'd1;
          seq_len_next = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
          pend_wr      = 1'b1;
          count_next   = 2'd1;
          seq_len_next = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
          pend_wr      = 1'b1;
          count_next   = 2'd1;
          seq_len_next = 3'd4;
        end else begin
          halted_next      = 1'b1;
          halt_status_next = u8u16_pkg::ST_UNSUPPORTED;
        end
      end else if (total >= seq_len) begin
        count_next   = 2'd0;
        seq_len_next = 3'd0;
        if (!cont_ok) begin
          halted_next      = 1'b1;
          halt_status_next = u8u16_pkg::ST_MALFORMED;
        end else begin
          job.has_point = 1'b1;
          case (total)
            3'd2:    job.point = {10'd0, pend[0][4:0], b[5:0]};
            3'd3:    job.point = {5'd0, pend[0][3:0], pend[1][5:0], b[5:0]};
            default: job.point = {pend[0][2:0], pend[1][5:0], pend[2][5:0], b[5:0]};
          endcase
        end
      end else begin
        // hold the continuation until the sequence is complete
        pend_wr    = 1'b1;
        count_next = total[1:0];
      end
    end

    for (int i = 0; i < u8u16_pkg::PENDING_DEPTH; i++) begin
      pend_view[i] = (pend_wr && pend_idx == 2'(i)) ? b : pend[i];
    end

    if (symbol.end_of_string) begin
      job.has_status = 1'b1;
      if (halted_next) begin
        job.status = halt_status_next;
      end else if (count_next != 2'd0) begin
        job.rem_count = count_next;
        job.rem_bytes = pend_view;
        job.status    = u8u16_pkg::ST_INCOMPLETE;
      end else begin
        job.status = u8u16_pkg::ST_CLEAN;
      end
      halted_next      = 1'b0;
      halt_status_next = u8u16_pkg::ST_CLEAN;
      count_next       = 2'd0;
      seq_len_next     = 3'd0;
    end
  end

  assign job_valid = accept && (job.has_point || job.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= 2'd0;
      seq_len     <= 3'd0;
      halted      <= 1'b0;
      halt_status <= u8u16_pkg::ST_CLEAN;
    end else if (accept) begin
      count       <= count_next;
      seq_len     <= seq_len_next;
      halted      <= halted_next;
      halt_status <= halt_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pend_wr) begin
      pend[pend_idx] <= b;
    end
  end

endmodule

### rtl/u8u16_queue.sv
module u8u16_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  u8u16_pkg::job_t wr_job,
  input  logic            rd_en,
  output u8u16_pkg::job_t rd_job,
  output logic            not_empty,
  output logic            full
);

  localparam int PTR_W = (u8u16_pkg::QUEUE_DEPTH > 1) ? $clog2(u8u16_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(u8u16_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(u8u16_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(u8u16_pkg::QUEUE_DEPTH);

  u8u16_pkg::job_t  entries [u8u16_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rd_job    = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == DEPTH_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

### rtl/u8u16_back.sv
module u8u16_back (
  input  logic               clk,
  input  logic               rst,
  input  u8u16_pkg::job_t    job,
  input  logic               job_valid,
  output logic               job_done,
  input  logic               pop,
  output logic               empty,
  output u8u16_pkg::result_t result
);

  logic                   out_valid;
  logic [1:0]             step;
  logic                   pair;
  logic [1:0]             n_point;
  logic [2:0]             n_total;
  logic [2:0]             rem_end;
  logic                   last;
  logic                   advance;
  logic [20:0]            diff;
  logic [15:0]            high_unit;
  logic [15:0]            low_unit;
  logic [1:0]             rem_idx;
  u8u16_pkg::result_t     next_result;

  assign pair = !job.utf32
             && ((job.point >= u8u16_pkg::SURR_FIRST && job.point <= u8u16_pkg::SURR_LAST)
              || job.point >= u8u16_pkg::SUPP_BASE);

  assign n_point = !job.has_point ? 2'd0 : (pair ? 2'd2 : 2'd1);
  assign rem_end = {1'b0, n_point} + {1'b0, job.rem_count};
  assign n_total = rem_end + {2'd0, job.has_status};
  assign last    = ({1'b0, step} + 3'd1) == n_total;
  assign rem_idx = step - n_point;

  // the pair is built from the low 20 bits of (point - 0x10000)
  assign diff      = job.point - u8u16_pkg::SUPP_BASE;
  assign high_unit = u8u16_pkg::SURR_HIGH_BASE + {6'd0, diff[19:10]};
  assign low_unit  = u8u16_pkg::SURR_LOW_BASE + {6'd0, diff[9:0]};

  always_comb begin
    next_result             = '0;
    next_result.last_result = last;
    if ({1'b0, step} < {1'b0, n_point}) begin
      next_result.kind = u8u16_pkg::KIND_UNIT;
      if (!pair) begin
        next_result.value = job.point;
      end else if (step == 2'd0) begin
        next_result.value = {5'd0, high_unit};
      end else begin
        next_result.value = {5'd0, low_unit};
      end
    end else if ({1'b0, step} < rem_end) begin
      next_result.kind  = u8u16_pkg::KIND_REMAINDER;
      next_result.value = {13'd0, job.rem_bytes[rem_idx]};
    end else begin
      next_result.kind       = u8u16_pkg::KIND_STATUS;
      next_result.end_status = job.status;
    end
  end

  assign advance  = job_valid && (!out_valid || pop);
  assign job_done = advance && last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 2'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      step      <= last ? 2'd0 : step + 2'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= next_result;
    end
  end

endmodule

### verif/transcoder_checker.sv
`timescale 1ns / 1ps

module transcoder_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  u8u16_pkg::symbol_t symbol,
  input  logic               pop,
  input  logic               empty,
  input  u8u16_pkg::result_t result,
  input  logic               cfg_write,
  input  logic               cfg_data,
  output int unsigned        errors,
  output int unsigned        outstanding,
  output int unsigned        results_checked,
  output int unsigned        strings_ended
);

  localparam int PRINT_LIMIT = 40;

  // Decoder state as the block should hold it
  logic [7:0]         held_bytes [3];
  int                 held_count;
  int                 char_length;
  logic               string_halted;
  u8u16_pkg::status_t halt_code;
  logic               utf32_mode;

  u8u16_pkg::result_t step_results[$];
  u8u16_pkg::result_t expected_units[$];

  int unsigned error_total;
  int unsigned checked_total;
  int unsigned ended_total;

  task automatic report_mismatch(input string what, input int got, input int want);
    error_total++;
    if (error_total <= PRINT_LIMIT)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic add_result(input u8u16_pkg::kind_t k, input logic [20:0] v,
                            input u8u16_pkg::status_t s);
    u8u16_pkg::result_t r;
    r.kind        = k;
    r.value       = v;
    r.end_status  = s;
    r.last_result = 1'b0;
    step_results.insert(step_results.size(), r);
  endtask

  task automatic emit_point(input logic [20:0] point);
    logic [19:0] offset;
    if (utf32_mode || point < u8u16_pkg::SURR_FIRST
        || (point > u8u16_pkg::SURR_LAST && point < u8u16_pkg::SUPP_BASE)) begin
      add_result(u8u16_pkg::KIND_UNIT, point, u8u16_pkg::ST_CLEAN);
    end else begin
      // Surrogate values and supplementary points both go out as a pair
      offset = 20'(point - u8u16_pkg::SUPP_BASE);
      add_result(u8u16_pkg::KIND_UNIT,
                 21'(u8u16_pkg::SURR_HIGH_BASE + 16'(offset[19:10])), u8u16_pkg::ST_CLEAN);
      add_result(u8u16_pkg::KIND_UNIT,
                 21'(u8u16_pkg::SURR_LOW_BASE + 16'(offset[9:0])), u8u16_pkg::ST_CLEAN);
    end
  endtask

  task automatic halt_string(input u8u16_pkg::status_t s);
    string_halted = 1'b1;
    halt_code     = s;
    held_count    = 0;
    char_length   = 0;
  endtask

  task automatic clear_string();
    foreach (held_bytes[i]) held_bytes[i] = 8'h00;
    held_count    = 0;
    char_length   = 0;
    string_halted = 1'b0;
    halt_code     = u8u16_pkg::ST_CLEAN;
  endtask

  task automatic start_char(input logic [7:0] lead, input int len);
    held_bytes[0] = lead;
    held_count    = 1;
    char_length   = len;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic        trail_ok;
    logic [20:0] point;
    step_results.delete();
    if (!string_halted) begin
      if (held_count == 0) begin
        if (b[7:6] == 2'b10) halt_string(u8u16_pkg::ST_STRAY);
        else if (!b[7]) emit_point({13'd0, b});
        else if (b[7:5] == 3'b110) start_char(b, 2);
        else if (b[7:4] == 4'b1110) start_char(b, 3);
        else if (b[7:3] == 5'b11110) start_char(b, 4);
        else halt_string(u8u16_pkg::ST_UNSUPPORTED);
      end else if (held_count + 1 >= char_length) begin
        trail_ok = (b[7:6] == 2'b10);
        for (int i = 1; i < held_count; i++)
          if (held_bytes[i][7:6] != 2'b10) trail_ok = 1'b0;
        if (!trail_ok) begin
          halt_string(u8u16_pkg::ST_MALFORMED);
        end else begin
          case (char_length)
            2: point = {16'd0, held_bytes[0][4:0]};
            3: point = {17'd0, held_bytes[0][3:0]};
            default: point = {18'd0, held_bytes[0][2:0]};
          endcase
          for (int i = 1; i < held_count; i++)
            point = {point[14:0], held_bytes[i][5:0]};
          point = {point[14:0], b[5:0]};
          held_count  = 0;
          char_length = 0;
          emit_point(point);
        end
      end else begin
        held_bytes[held_count] = b;
        held_count++;
      end
    end

    if (eos) begin
      if (string_halted) begin
        add_result(u8u16_pkg::KIND_STATUS, 21'd0, halt_code);
      end else if (held_count > 0) begin
        // Hand back the cut-off bytes unchecked, then flag the string as incomplete
        for (int i = 0; i < held_count; i++)
          add_result(u8u16_pkg::KIND_REMAINDER, {13'd0, held_bytes[i]}, u8u16_pkg::ST_CLEAN);
        add_result(u8u16_pkg::KIND_STATUS, 21'd0, u8u16_pkg::ST_INCOMPLETE);
      end else begin
        add_result(u8u16_pkg::KIND_STATUS, 21'd0, u8u16_pkg::ST_CLEAN);
      end
      clear_string();
    end

    if (step_results.size() > 0)
      step_results[step_results.size() - 1].last_result = 1'b1;
    foreach (step_results[i]) expected_units.insert(expected_units.size(), step_results[i]);
  endtask

  task automatic check_result(input u8u16_pkg::result_t got);
    u8u16_pkg::result_t want;
    if (expected_units.size() == 0) begin
      report_mismatch("result with nothing expected", int'(got), 0);
    end else begin
      want = expected_units.pop_front();
      if (got.kind !== want.kind)
        report_mismatch("kind", int'(got.kind), int'(want.kind));
      if (got.value !== want.value)
        report_mismatch("value", int'(got.value), int'(want.value));
      if (got.end_status !== want.end_status)
        report_mismatch("end_status", int'(got.end_status), int'(want.end_status));
      if (got.last_result !== want.last_result)
        report_mismatch("last_result", int'(got.last_result), int'(want.last_result));
      if (got.kind === u8u16_pkg::KIND_STATUS) ended_total++;
    end
    checked_total++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      utf32_mode = 1'b0;
      expected_units.delete();
    end else begin
      if (pop && !empty) check_result(result);
      if (push && !full) decode_byte(symbol.byte_in, symbol.end_of_string);
      if (cfg_write) utf32_mode = cfg_data;
    end
    errors          <= error_total;
    outstanding     <= expected_units.size();
    results_checked <= checked_total;
    strings_ended   <= ended_total;
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASE_BYTES    = 75;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 120;

  typedef enum int {
    FAULT_NONE,
    FAULT_STRAY,
    FAULT_LEAD,
    FAULT_BAD_TRAIL,
    FAULT_CUT
  } fault_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  u8u16_pkg::symbol_t symbol = '0;
  logic               pop = 1'b0;
  logic               empty;
  u8u16_pkg::result_t result;
  logic               cfg_write = 1'b0;
  logic               cfg_data = 1'b0;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned strings_ended;

  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned bytes_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf8_to_utf16_transcoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .symbol    (symbol),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  transcoder_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .symbol          (symbol),
    .pop             (pop),
    .empty           (empty),
    .result          (result),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .strings_ended   (strings_ended)
  );

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    symbol <= '{byte_in: b, end_of_string: eos};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    bytes_sent += text.size();
  endtask

  // Hold the input low until every request has drained and the decoder has settled
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(input int idle_pct, input int stall_pct, input logic utf32);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= utf32;
    @(posedge clk);
    cfg_write      <= 1'b0;
    recv_stall_pct <= stall_pct;
    send_idle_pct   = idle_pct;
  endtask

  task automatic add_char(ref logic [7:0] text[$], input int len);
    case (len)
      1: text.insert(text.size(), {1'b0, 7'($urandom)});
      2: text.insert(text.size(), {3'b110, 5'($urandom)});
      3: text.insert(text.size(), {4'b1110, 4'($urandom)});
      default: text.insert(text.size(), {5'b11110, 3'($urandom)});
    endcase
    for (int i = 1; i < len; i++) text.insert(text.size(), {2'b10, 6'($urandom)});
  endtask

  task automatic send_random_string();
    logic [7:0] text[$];
    fault_t     fault;
    int         chars;
    int         hit;
    int         len;
    int         first;
    int         keep;
    int         live;
    logic [7:0] b;
    chars = $urandom_range(1, 6);
    hit   = $urandom_range(0, chars - 1);
    live  = -1;
    if ($urandom_range(99) < 70) fault = FAULT_NONE;
    else fault = fault_t'($urandom_range(FAULT_STRAY, FAULT_CUT));

    for (int c = 0; c < chars; c++) begin
      if (c == hit && fault == FAULT_STRAY) begin
        text.insert(text.size(), {2'b10, 6'($urandom)});
        live = text.size();
      end
      if (c == hit && fault == FAULT_LEAD) begin
        text.insert(text.size(), {5'b11111, 3'($urandom)});
        live = text.size();
      end
      first = text.size();
      if (c == hit && (fault == FAULT_BAD_TRAIL || fault == FAULT_CUT))
        len = $urandom_range(2, 4);
      else
        len = $urandom_range(1, 4);
      add_char(text, len);
      if (c == hit && fault == FAULT_BAD_TRAIL) begin
        do b = 8'($urandom); while (b[7:6] == 2'b10);
        text[first + $urandom_range(1, len - 1)] = b;
        live = first + len;
      end
      if (c == hit && fault == FAULT_CUT) begin
        keep = $urandom_range(1, len - 1);
        while (text.size() > first + keep) void'(text.pop_back());
        break;
      end
    end

    // Bytes after a halt are dropped by the block, so leave them out of the tally
    if (live < 0) live = text.size();
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    bytes_sent += live;
  endtask

  task automatic run_random(input int count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_string();
  endtask

  initial begin
    logic [7:0] text[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    start_phase(0, 0, 1'b0);

    // Directed: range ends, surrogates, largest point, and every way a string can end
    text = {8'h00, 8'h7F};
    send_text(text);
    text = {8'hC2, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_text(text);
    text = {8'hEF, 8'hBF, 8'hBF};
    send_text(text);
    text = {8'h80, 8'h41};
    send_text(text);
    text = {8'hFF};
    send_text(text);
    text = {8'hF8};
    send_text(text);
    text = {8'hC3, 8'h41};
    send_text(text);
    text = {8'hF0, 8'h90, 8'h80};
    send_text(text);

    // Back-to-back with a long receiver hold-off so the input stalls
    start_phase(0, 0, 1'b1);
    hold_off <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_random(PHASE_BYTES);

    start_phase(86, 0, 1'b0);
    run_random(PHASE_BYTES);
    start_phase(0, 86, 1'b1);
    run_random(PHASE_BYTES);
    start_phase(23, 23, 1'b0);
    run_random(PHASE_BYTES);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d live bytes in %0d strings; checked %0d results in both output modes",
             bytes_sent, strings_ended, results_checked);
    $display("Idling patterns: none, sender, receiver, both, plus one long output hold-off");
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results still expected", errors, outstanding);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
